### design/spd_pkg.sv
// spd_pkg: shared types and constants of the sequence period detector
// no dependencies; used by spd_out_if, sequence_period_detector_top and the bench
`default_nettype none

package spd_pkg;

    // width of the reported period field
    localparam int PERIOD_W = 9;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_READ,
        ST_CMP,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

### design/spd_in_if.sv
// spd_in_if: valid/ready channel carrying one sequence element and its last flag
// no dependencies
`default_nettype none

interface spd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

### design/spd_out_if.sv
// spd_out_if: valid/ready channel carrying one search result
// depends on spd_pkg for the period width
`default_nettype none

interface spd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [spd_pkg::PERIOD_W-1:0]  period_length;
    logic                          overflow;

    modport source (output valid, output found, output period_length, output overflow,
                    input ready);
    modport sink   (input valid, input found, input period_length, input overflow,
                    output ready);
endinterface

`default_nettype wire

### design/spd_ram.sv
// spd_ram: generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module spd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### design/sequence_period_detector_top.sv
// sequence_period_detector_top: stores a sequence and searches it for its smallest period
// depends on spd_pkg, spd_in_if, spd_out_if and spd_ram
//
// usage
//   i_in carries one element per transaction (sample, last). while loading, ready is high
//   and one element is taken every cycle. elements beyond MAX_LEN are dropped and the
//   result then reports overflow. the element marked last closes the sequence and
//   starts the search; ready stays low until the search has finished.
//   o_out carries one result per sequence: found, period_length (smallest shift, 0 when
//   none) and overflow. it sits in an output register, so loading of the next sequence
//   goes on while the result waits to be taken.
// timing
//   search: each element pair compare goes through ST_READ (address) and then ST_CMP
//   (registered read of both ram ports), tried shift by shift, so the search time grows
//   with the number of compared pairs over all tried shifts; ST_INIT does the setup and
//   ST_FIN the hand-over. a short sequence (under 4 elements) goes from ST_INIT straight
//   to ST_FIN, and ready returns high in the same cycle that its result turns valid.
// reset
//   synchronous active-low reset clears the element count, overflow flag, state and
//   output valid; the ram contents are not cleared. if o_out is stalled when the search
//   ends, the block holds the result internally until the output register frees.
`default_nettype none

module sequence_period_detector_top #(
    parameter int MAX_LEN     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spd_in_if.sink    i_in,
    spd_out_if.source o_out
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SW    = CNT_W + 1;

    spd_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_len, n_len;
    logic             r_len_ovf, n_len_ovf;
    logic [CNT_W-1:0] r_s, n_s;
    logic [CNT_W-1:0] r_p, n_p;
    logic             r_hit, n_hit;

    logic                         r_out_valid, n_out_valid;
    logic                         r_found, n_found;
    logic [spd_pkg::PERIOD_W-1:0] r_period, n_period;
    logic                         r_out_ovf, n_out_ovf;

    logic             w_accept;
    logic             w_room;
    logic             w_we;
    logic [CNT_W-1:0] w_half;
    logic [SW-1:0]    w_s_next;
    logic [SW-1:0]    w_pair_end;
    logic [CNT_W-1:0] w_pb;
    logic [AW-1:0]    w_raddr_a;
    logic [AW-1:0]    w_raddr_b;
    logic [SAMPLE_BITS-1:0] w_rd_a;
    logic [SAMPLE_BITS-1:0] w_rd_b;

    assign i_in.ready = (r_state == spd_pkg::ST_LOAD);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_room     = (r_cnt < CNT_W'(MAX_LEN));
    assign w_we       = w_accept && w_room;

    assign w_half     = r_len >> 1;
    assign w_s_next   = SW'(r_s) + SW'(1);
    // index of the pair after this one, compared against the length
    assign w_pair_end = SW'(r_p) + SW'(r_s) + SW'(1);
    assign w_pb       = r_p + r_s;
    assign w_raddr_a  = r_p[AW-1:0];
    assign w_raddr_b  = w_pb[AW-1:0];

    spd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_cnt[AW-1:0]),
        .i_wdata   (i_in.sample),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spd_pkg::ST_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_len_ovf <= n_len_ovf;
        r_s       <= n_s;
        r_p       <= n_p;
        r_hit     <= n_hit;
        r_found   <= n_found;
        r_period  <= n_period;
        r_out_ovf <= n_out_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_len       = r_len;
        n_len_ovf   = r_len_ovf;
        n_s         = r_s;
        n_p         = r_p;
        n_hit       = r_hit;
        n_found     = r_found;
        n_period    = r_period;
        n_out_ovf   = r_out_ovf;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            spd_pkg::ST_LOAD: begin
                if (w_accept) begin
                    if (i_in.last) begin
                        n_len     = w_room ? (r_cnt + CNT_W'(1)) : r_cnt;
                        n_len_ovf = r_ovf || !w_room;
                        n_cnt     = '0;
                        n_ovf     = 1'b0;
                        n_state   = spd_pkg::ST_INIT;
                    end else if (w_room) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            spd_pkg::ST_INIT: begin
                n_s = CNT_W'(1);
                n_p = CNT_W'(1);
                if (w_half <= CNT_W'(1)) begin
                    n_hit   = 1'b0;
                    n_state = spd_pkg::ST_FIN;
                end else begin
                    n_state = spd_pkg::ST_READ;
                end
            end
            spd_pkg::ST_READ: begin
                n_state = spd_pkg::ST_CMP;
            end
            spd_pkg::ST_CMP: begin
                if (w_rd_a != w_rd_b) begin
                    // mismatch: move on to the next shift, or finish without a hit when none is left
                    if (w_s_next >= SW'(w_half)) begin
                        n_hit   = 1'b0;
                        n_state = spd_pkg::ST_FIN;
                    end else begin
                        n_s     = w_s_next[CNT_W-1:0];
                        n_p     = CNT_W'(1);
                        n_state = spd_pkg::ST_READ;
                    end
                end else if (w_pair_end >= SW'(r_len)) begin
                    n_hit   = 1'b1;
                    n_state = spd_pkg::ST_FIN;
                end else begin
                    n_p     = r_p + CNT_W'(1);
                    n_state = spd_pkg::ST_READ;
                end
            end
            spd_pkg::ST_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_period    = r_hit ? spd_pkg::PERIOD_W'(r_s) : '0;
                    n_out_ovf   = r_len_ovf;
                    n_state     = spd_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = spd_pkg::ST_LOAD;
            end
        endcase
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_found;
    assign o_out.period_length = r_period;
    assign o_out.overflow      = r_out_ovf;

    // the element count never runs past the store depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_LEN))
        else $error("element count beyond store depth");

    // every compared pair lies inside the stored sequence
    a_pair_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spd_pkg::ST_CMP) |-> (SW'(r_p) + SW'(r_s) < SW'(r_len)))
        else $error("compare outside stored sequence");

    // a closing transaction always starts the search
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.last) |=> (r_state == spd_pkg::ST_INIT))
        else $error("last element did not start the search");

    // a not-found result carries a zero period
    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_period == '0))
        else $error("period set without a hit");

endmodule

`default_nettype wire

### verif/sequence_period_detector_top_tb.sv
// sequence_period_detector_top_tb: self-checking bench for the smallest period search
// depends on spd_pkg, spd_in_if, spd_out_if and the sequence_period_detector_top design files
`default_nettype none

module sequence_period_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN        = 1024;
    localparam int SAMPLE_BITS    = 16;
    localparam int RANDOM_ITEMS   = 800;
    localparam int FULL_PERIOD    = 511;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 20;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic                         found;
        logic [spd_pkg::PERIOD_W-1:0] period_length;
        logic                         overflow;
    } t_period_result;

    logic i_clk;
    logic i_rst_n;

    spd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
    spd_out_if out_if ();

    sequence_period_detector_top #(
        .MAX_LEN    (MAX_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // bench copy of the sequence being loaded
    t_sample        seq_store [MAX_LEN];
    int unsigned    stored_count;
    bit             dropped_seen;
    t_period_result pending_results [$];
    t_period_result next_result;
    int unsigned    fail_count;
    int unsigned    quiet_cycles;
    bit             in_no_idle;
    bit             out_no_idle;
    int unsigned    out_stall;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int unsigned draw_gap(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // smallest shift s, 1 <= s < len/2, with store[p] == store[p+s] for p = 1 .. len-s-1
    function automatic int unsigned smallest_shift(int unsigned len);
        int unsigned s;
        int unsigned p;
        bit          match;
        for (s = 1; s < len / 2; s++) begin
            match = 1'b1;
            for (p = 1; p + s < len; p++) begin
                if (seq_store[p] != seq_store[p + s]) begin
                    match = 1'b0;
                    break;
                end
            end
            if (match) begin
                return s;
            end
        end
        return 0;
    endfunction

    task automatic record_sample(input t_sample value, input logic is_last);
        int unsigned    shift;
        t_period_result want;
        if (stored_count < MAX_LEN) begin
            seq_store[stored_count] = value;
            stored_count++;
        end else begin
            dropped_seen = 1'b1;
        end
        if (is_last) begin
            shift              = smallest_shift(stored_count);
            want.found         = (shift != 0);
            want.period_length = shift[spd_pkg::PERIOD_W-1:0];
            want.overflow      = dropped_seen;
            pending_results    = {pending_results, want};
            stored_count = 0;
            dropped_seen = 1'b0;
        end
    endtask

    // called and returns at a falling edge
    task automatic push_sample(input t_sample value, input logic is_last);
        int unsigned gap;
        gap = draw_gap(in_no_idle);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= value;
        in_if.last   <= is_last;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        record_sample(value, is_last);
        @(negedge i_clk);
    endtask

    task automatic run_sequence(input t_sample elems [$]);
        foreach (elems[k]) begin
            push_sample(elems[k], k == elems.size() - 1);
        end
    endtask

    // short sequences, first element excluded from compares, field extremes
    task automatic test_directed();
        t_sample elems [$];
        in_no_idle  = 1'b0;
        out_no_idle = 1'b0;
        elems = '{16'h8000};
        run_sequence(elems);
        elems = '{16'h7fff, 16'h7fff};
        run_sequence(elems);
        elems = '{16'hffff, 16'hffff, 16'hffff};
        run_sequence(elems);
        // shortest length that can match
        elems = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        run_sequence(elems);
        // element zero differs but the rest repeats with period 2
        elems = '{16'h8000, 16'h7fff, 16'h0001, 16'h7fff, 16'h0001, 16'h7fff};
        run_sequence(elems);
        elems = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000, 16'h0000, 16'h0001};
        run_sequence(elems);
    endtask

    // fill the store past its depth, closing element dropped, longest reportable period
    task automatic test_store_overflow();
        t_sample elems [$];
        t_sample base [$];
        int      k;
        for (k = 0; k < FULL_PERIOD; k++) begin
            base = {base, t_sample'($urandom)};
        end
        elems = {elems, t_sample'($urandom)};
        for (k = 1; k < MAX_LEN + 2; k++) begin
            elems = {elems, base[(k - 1) % FULL_PERIOD]};
        end
        in_no_idle  = 1'b1;
        out_no_idle = 1'b0;
        run_sequence(elems);
    endtask

    task automatic test_random_sequences();
        t_sample     elems [$];
        t_sample     base [$];
        t_sample     alpha0;
        t_sample     alpha1;
        int unsigned len;
        int unsigned per;
        int unsigned pick;
        int unsigned kind;
        int unsigned sent;
        int unsigned k;
        bit          small_alpha;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            elems.delete();
            base.delete();
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                len = $urandom_range(65, 200);
            end else if (pick < 6) begin
                len = $urandom_range(25, 64);
            end else begin
                len = $urandom_range(1, 24);
            end
            per         = (len >= 2) ? $urandom_range(1, len / 2) : 1;
            alpha0      = t_sample'($urandom);
            alpha1      = t_sample'($urandom);
            small_alpha = $urandom_range(0, 1);
            // 0: periodic, 1: periodic with one bad element, 2: two values, 3: noise
            kind = $urandom_range(0, 3);
            for (k = 0; k < per; k++) begin
                if (small_alpha) begin
                    base = {base, ($urandom_range(0, 1) ? alpha0 : alpha1)};
                end else begin
                    base = {base, t_sample'($urandom)};
                end
            end
            elems = {elems, t_sample'($urandom)};
            for (k = 1; k < len; k++) begin
                case (kind)
                    0, 1: begin
                        elems = {elems, base[(k - 1) % per]};
                    end
                    2: begin
                        elems = {elems, ($urandom_range(0, 1) ? alpha0 : alpha1)};
                    end
                    default: begin
                        elems = {elems, t_sample'($urandom)};
                    end
                endcase
            end
            if (kind == 1 && len > 1) begin
                elems[$urandom_range(1, len - 1)] = t_sample'($urandom);
            end
            in_no_idle  = ($urandom_range(0, 4) == 0);
            out_no_idle = ($urandom_range(0, 4) == 0);
            run_sequence(elems);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.sample = '0;
        in_if.last   = 1'b0;
        stored_count = 0;
        dropped_seen = 1'b0;
        fail_count   = 0;
        in_no_idle   = 1'b0;
        out_no_idle  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_store_overflow();
        test_random_sequences();
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS sequence_period_detector_top");
        end else begin
            $display("FAIL sequence_period_detector_top");
        end
        $finish;
    end

    // result side back-pressure
    initial begin
        out_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) begin
            @(negedge i_clk);
        end
        forever begin
            out_stall = draw_gap(out_no_idle);
            if (out_stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (out_stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (out_if.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with none pending: found=%0d period_length=%0d overflow=%0d",
                       out_if.found, out_if.period_length, out_if.overflow);
                fail_count++;
            end else begin
                next_result = pending_results.pop_front();
                if (out_if.found !== next_result.found) begin
                    $error("found: expected %0d, got %0d", next_result.found, out_if.found);
                    fail_count++;
                end
                if (out_if.period_length !== next_result.period_length) begin
                    $error("period_length: expected %0d, got %0d",
                           next_result.period_length, out_if.period_length);
                    fail_count++;
                end
                if (out_if.overflow !== next_result.overflow) begin
                    $error("overflow: expected %0d, got %0d",
                           next_result.overflow, out_if.overflow);
                    fail_count++;
                end
            end
        end
    end

    // a long search holds ready low, so the limit covers the slowest sequence used here
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) === 1'b1 || (out_if.valid && out_if.ready) === 1'b1)
        begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL sequence_period_detector_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        quiet_cycles = 0;
    end

endmodule

`default_nettype wire
